>>> rtl/core/dice_pkg.sv
`default_nettype none
package dice_pkg;
    localparam int DATA_W = 16;
    localparam int NCOL_W = 11;
    localparam int COL_W  = 10;
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_PROCESS = 1'b1;

    typedef struct packed {
        logic                     action;
        logic [COL_W-1:0]         column_index;
        logic signed [DATA_W-1:0] x_value;
        logic signed [DATA_W-1:0] mean_value;
        logic signed [DATA_W-1:0] rvar_value;
        logic signed [DATA_W-1:0] gamma_value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] y_value;
        logic                     column_error;
    } rsp_t;

    // Sigmoid at integer knots 0..8 in unsigned Q0.16 (knot 0 is 0.5).
    function automatic logic [16:0] sig_knot(input logic [3:0] k);
        logic [16:0] r;
        begin
            case (k)
                4'd0: r = 17'd32768;
                4'd1: r = 17'd47911;
                4'd2: r = 17'd57724;
                4'd3: r = 17'd62428;
                4'd4: r = 17'd64357;
                4'd5: r = 17'd65097;
                4'd6: r = 17'd65374;
                4'd7: r = 17'd65476;
                default: r = 17'd65514;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

>>> rtl/core/dice_if.sv
`default_nettype none
interface dice_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/dice_ram.sv
`default_nettype none
module dice_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/core/dice_activation_unit.sv
`default_nettype none
// Dice activation unit. Load requests (action 0) write one column's mean,
// reciprocal variance and gamma into a 1024-entry column RAM; process
// requests (action 1) return y = x*(gamma + (1-gamma)*sigmoid((x-mean)*rvar))
// in saturated Q8.8, or zero with column_error set when the column is not
// below num_cols. One request is in flight at a time: a process request
// passes the RAM read, then five stages of multiply and table interpolation
// and the output register before its response is presented; a load is
// done when it is accepted. A new request is accepted only while the
// pipeline is empty and no response waits, or in the cycle the waiting
// response is taken, so a process request occupies the block until its
// response is taken. Reading a column never loaded gives undefined results.
module dice_activation_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    dice_if.sink      in_ch,
    dice_if.source    out_ch,
    input  wire logic cfg_valid,
    output logic      cfg_ready,
    input  wire logic [dice_pkg::NCOL_W-1:0] cfg_data
);
    localparam int F = 8;

    logic [dice_pkg::NCOL_W-1:0] num_cols_reg;
    logic [6:0] stg_reg, stg_next;   // stage valid shift
    logic busy;
    logic acc;
    logic out_valid_reg;
    dice_pkg::rsp_t out_reg;

    assign cfg_ready = 1'b1;
    assign busy = |stg_reg;
    assign in_ch.ready = !busy && (!out_valid_reg || out_ch.ready);
    assign acc = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg <= 11'd1024;
        end
        else if (cfg_valid)
        begin
            num_cols_reg <= cfg_data;
        end
    end

    // RAM: {mean, rvar, gamma}
    logic [47:0] rd;
    dice_ram #(.WIDTH(48), .DEPTH(1024)) u_ram (
        .clk(clk),
        .we(acc && in_ch.data.action == dice_pkg::ACT_LOAD),
        .waddr(in_ch.data.column_index),
        .wdata({in_ch.data.mean_value, in_ch.data.rvar_value, in_ch.data.gamma_value}),
        .raddr(in_ch.data.column_index),
        .rdata(rd)
    );

    // Stage 0: hold x and error
    logic signed [15:0] x0_reg;
    logic err0_reg;
    // Stage 1: d = x - mean
    logic signed [16:0] d1_reg;
    logic signed [15:0] r1_reg, g1_reg, x1_reg;
    logic err1_reg;
    // Stage 2: t
    logic signed [33:0] p2_reg;
    logic signed [15:0] g2_reg, x2_reg;
    logic err2_reg;
    // Stage 3: saturate, split, interpolate multiply
    logic neg3_reg;
    logic [16:0] base3_reg;
    logic [25:0] prod3_reg;
    logic signed [15:0] g3_reg, x3_reg;
    logic err3_reg;
    // Stage 4: s, g
    logic signed [41:0] gt4_reg;
    logic signed [15:0] x4_reg;
    logic err4_reg;
    // Stage 5: x*g
    logic signed [57:0] y5_reg;
    logic err5_reg;

    logic signed [33:0] tsat;
    logic [11:0] aval;
    logic [16:0] k0, k1, s3;

    always_comb
    begin
        tsat = p2_reg >>> F;
        if (tsat > 34'sd2048) tsat = 34'sd2048;
        if (tsat < -34'sd2048) tsat = -34'sd2048;
        aval = tsat[33] ? 12'(-tsat) : 12'(tsat);
        k0 = dice_pkg::sig_knot(aval[11:8]);
        k1 = dice_pkg::sig_knot(4'(aval[11:8] + 4'd1));
        s3 = base3_reg + 17'(prod3_reg >> F);
        if (neg3_reg) s3 = 17'd65536 - s3;
    end

    logic [17:0] diffk;
    assign diffk = (aval[11:8] >= 4'd8) ? 18'd0 : {1'b0, k1} - {1'b0, k0};

    logic signed [57:0] ysh;
    assign ysh = y5_reg >>> (F + 16);

    always_comb
    begin
        stg_next = {stg_reg[5:0], acc && in_ch.data.action == dice_pkg::ACT_PROCESS};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            stg_reg <= {stg_next[6:1], stg_next[0]} & 7'b0111111;
            if (stg_reg[5])
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg <= in_ch.data.x_value;
        err0_reg <= {1'b0, in_ch.data.column_index} >= num_cols_reg;
        d1_reg <= 17'(x0_reg) - 17'($signed(rd[47:32]));
        r1_reg <= rd[31:16];
        g1_reg <= rd[15:0];
        x1_reg <= x0_reg;
        err1_reg <= err0_reg;
        p2_reg <= d1_reg * 34'(r1_reg);
        g2_reg <= g1_reg;
        x2_reg <= x1_reg;
        err2_reg <= err1_reg;
        neg3_reg <= tsat[33];
        base3_reg <= k0;
        prod3_reg <= 26'(diffk[16:0] * aval[7:0]);
        g3_reg <= g2_reg;
        x3_reg <= x2_reg;
        err3_reg <= err2_reg;
        gt4_reg <= (42'(g3_reg) <<< 16)
            + 42'(($signed(17'sd256) - 17'(g3_reg)) * $signed({1'b0, s3}));
        x4_reg <= x3_reg;
        err4_reg <= err3_reg;
        y5_reg <= 58'(x4_reg) * 58'(gt4_reg);
        err5_reg <= err4_reg;
        if (stg_reg[5])
        begin
            out_reg.column_error <= err5_reg;
            if (err5_reg)
                out_reg.y_value <= '0;
            else if (ysh > 58'sd32767)
                out_reg.y_value <= 16'sh7fff;
            else if (ysh < -58'sd32768)
                out_reg.y_value <= -16'sh8000;
            else
                out_reg.y_value <= ysh[15:0];
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = out_reg;
endmodule
`default_nettype wire

>>> tb/sv/dice_if.sv
`timescale 1ns / 100ps
// The channel interface is shared with the RTL and is defined with the core sources.

>>> tb/sv/dice_activation_unit_tb.sv
`timescale 1ns / 100ps
module dice_activation_unit_tb;

    class dice_scoreboard;
        logic signed [15:0] mean_tab [0:1023];
        logic signed [15:0] rvar_tab [0:1023];
        logic signed [15:0] gamma_tab [0:1023];
        logic [10:0] col_limit;
        dice_pkg::rsp_t pending_y [$];
        int mismatches;

        function new();
            col_limit = 11'd1024;
            mismatches = 0;
        endfunction

        function automatic longint floor_div(longint v, int sh);
            return v >>> sh;
        endfunction

        function automatic longint sigmoid_q16(longint t);
            longint a, i, f, s, k0, k1;
            a = (t < 0) ? -t : t;
            i = a >> 8;
            f = a & 255;
            if (i >= 8)
                s = 65514;
            else
            begin
                case (i)
                    0: begin k0 = 32768; k1 = 47911; end
                    1: begin k0 = 47911; k1 = 57724; end
                    2: begin k0 = 57724; k1 = 62428; end
                    3: begin k0 = 62428; k1 = 64357; end
                    4: begin k0 = 64357; k1 = 65097; end
                    5: begin k0 = 65097; k1 = 65374; end
                    6: begin k0 = 65374; k1 = 65476; end
                    default: begin k0 = 65476; k1 = 65514; end
                endcase
                s = k0 + (((k1 - k0) * f) >> 8);
            end
            if (t < 0)
                s = 65536 - s;
            return s;
        endfunction

        function void note_request(dice_pkg::req_t r);
            longint x, d, t, s, g, y, gm;
            dice_pkg::rsp_t e;
            if (r.action == dice_pkg::ACT_LOAD)
            begin
                mean_tab[r.column_index] = r.mean_value;
                rvar_tab[r.column_index] = r.rvar_value;
                gamma_tab[r.column_index] = r.gamma_value;
                return;
            end
            if ({1'b0, r.column_index} >= col_limit)
            begin
                e.y_value = '0;
                e.column_error = 1'b1;
            end
            else
            begin
                x = r.x_value;
                d = x - longint'(mean_tab[r.column_index]);
                t = floor_div(d * longint'(rvar_tab[r.column_index]), 8);
                if (t > 2048) t = 2048;
                if (t < -2048) t = -2048;
                s = sigmoid_q16(t);
                gm = gamma_tab[r.column_index];
                g = gm * 65536 + (256 - gm) * s;
                y = floor_div(x * g, 24);
                if (y > 32767) y = 32767;
                if (y < -32768) y = -32768;
                e.y_value = y[15:0];
                e.column_error = 1'b0;
            end
            pending_y.push_back(e);
        endfunction

        function void check_response(dice_pkg::rsp_t got);
            dice_pkg::rsp_t e;
            if (pending_y.size() == 0)
            begin
                report_mismatch("response with none expected");
                return;
            end
            e = pending_y.pop_front();
            if (got.y_value !== e.y_value)
                report_mismatch($sformatf("y_value got %0d want %0d",
                    got.y_value, e.y_value));
            if (got.column_error !== e.column_error)
                report_mismatch($sformatf("column_error got %0b want %0b",
                    got.column_error, e.column_error));
        endfunction

        function void report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            mismatches++;
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [dice_pkg::NCOL_W-1:0] cfg_data = '0;
    dice_if #(.T(dice_pkg::req_t)) in_ch ();
    dice_if #(.T(dice_pkg::rsp_t)) out_ch ();

    dice_scoreboard board;
    int send_idle_pct = 0;
    int stall_pct = 0;
    bit long_hold = 1'b0;
    bit loaded [0:1023];
    int loaded_list [$];

    dice_activation_unit uut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off while the sender keeps offering.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
                board.check_response(out_ch.data);
            out_ch.ready <= !long_hold && ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_request(dice_pkg::req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= r;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        board.note_request(r);
        if (r.action == dice_pkg::ACT_LOAD && !loaded[r.column_index])
        begin
            loaded[r.column_index] = 1'b1;
            loaded_list.push_back(r.column_index);
        end
    endtask

    task automatic load_col(int col, int m, int rv, int gm);
        dice_pkg::req_t r;
        r = '0;
        r.action = dice_pkg::ACT_LOAD;
        r.column_index = 10'(col);
        r.x_value = 16'($urandom);
        r.mean_value = 16'(m);
        r.rvar_value = 16'(rv);
        r.gamma_value = 16'(gm);
        send_request(r);
    endtask

    task automatic process_col(int col, int x);
        dice_pkg::req_t r;
        r.action = dice_pkg::ACT_PROCESS;
        r.column_index = 10'(col);
        r.x_value = 16'(x);
        r.mean_value = 16'($urandom);
        r.rvar_value = 16'($urandom);
        r.gamma_value = 16'($urandom);
        send_request(r);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (board.pending_y.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_limit(int n);
        cfg_valid <= 1'b1;
        cfg_data <= 11'(n);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.col_limit = 11'(n);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Processes a loaded column, or an out-of-range one whose table entry does
    // not affect the result, so no unwritten entry is used.
    task automatic random_process();
        int col;
        if ($urandom_range(9) == 0 && board.col_limit < 1024)
            col = $urandom_range(1023, board.col_limit);
        else
            col = loaded_list[$urandom_range(loaded_list.size() - 1)];
        if (!loaded[col] && col < board.col_limit)
            col = loaded_list[0];
        process_col(col, $urandom);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(3) == 0)
                load_col($urandom_range(1023), $urandom, $urandom, $urandom);
            else
                random_process();
        end
    endtask

    initial
    begin
        board = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes of every field and both actions.
        load_col(0, 0, 256, 0);
        load_col(1023, -32768, 32767, 32767);
        load_col(5, 32767, -32768, -32768);
        load_col(7, 0, 0, 256);
        process_col(0, 0);
        process_col(0, 32767);
        process_col(0, -32768);
        process_col(1023, 32767);
        process_col(1023, -32768);
        process_col(5, 32767);
        process_col(5, -32768);
        process_col(7, 12345);
        process_col(0, 512);
        process_col(0, -3000);
        wait_idle();
        write_limit(1);
        process_col(0, 100);
        process_col(5, 100);
        process_col(1023, 100);
        wait_idle();
        write_limit(0);
        process_col(0, 100);
        wait_idle();
        write_limit(1024);

        for (int i = 0; i < 40; i++)
            load_col($urandom_range(1023), $urandom, $urandom, $urandom);
        random_phase(100);
        wait_idle();
        send_idle_pct = 82;
        random_phase(100);
        wait_idle();
        write_limit($urandom_range(1023, 1));
        send_idle_pct = 0;
        stall_pct = 82;
        random_phase(100);
        wait_idle();
        write_limit(512);
        send_idle_pct = 38;
        stall_pct = 38;
        random_phase(100);
        wait_idle();
        write_limit(1024);
        send_idle_pct = 0;
        stall_pct = 0;
        fork
            begin
                long_hold <= 1'b1;
                repeat (200) @(posedge clk);
                long_hold <= 1'b0;
            end
            random_phase(60);
        join
        random_phase(130);
        wait_idle();
        repeat (20) @(posedge clk);
        if (board.mismatches == 0 && board.pending_y.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end
endmodule
